// ===== design/mtrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtrr_pkg
// Shared constants, codes and control types for the memory-type range table.
// ----------------------------------------------------------------------------
package mtrr_pkg;

    localparam int MAX_RANGES = 8;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 31;
    localparam int EIDX_W     = 3;
    localparam int PFN_W      = 20;
    localparam int TYPE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int USED_W     = 3;
    localparam int RIU_W      = 4;

    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_CNT_W = LEN_W - PAGE_SHIFT;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [TYPE_W-1:0] TYPE_WC = TYPE_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_TYPE  = 2'd0,
        CFG_RANGES_IN_USE = 2'd1,
        CFG_WC_SUPPORTED  = 2'd2
    } cfg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP  = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_INSTALL = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE        = 3'd0,
        ST_COVERED     = 3'd1,
        ST_UNALIGNED   = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_NO_FREE     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_PAGE,
        S_FREE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    take;
        logic    idx_clr;
        logic    idx_inc;
        logic    page_next;
        logic    write_entry;
        logic    program_entry;
        logic    res_clear;
        logic    type_load;
        logic    status_load;
        status_t status;
        logic    used_load;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic  req_valid;
        func_t func;
        logic  bad_range;
        logic  wc_supported;
        logic  idx_end;
        logic  hit;
        logic  entry_valid;
        logic  type_is_wc;
        logic  last_page;
        logic  out_busy;
    } stat_t;

    // Page-frame mask of the power-of-two size that covers len (len nonzero).
    function automatic logic [PFN_W-1:0] mask_for_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]  m;
        logic [ADDR_W-1:0] inv;
        m = len - LEN_W'(1);
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        inv = ~{{(ADDR_W - LEN_W){1'b0}}, m};
        return inv[ADDR_W-1:PAGE_SHIFT];
    endfunction

endpackage
`default_nettype wire

// ===== design/mtrr_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtrr_req_if
// Request channel: operation code and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mtrr_req_if;
    import mtrr_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    length;
    logic [EIDX_W-1:0]   entry_index;
    logic [PFN_W-1:0]    entry_base;
    logic [PFN_W-1:0]    entry_mask;
    logic [TYPE_W-1:0]   entry_type;
    logic                entry_valid;

    modport source (
        output valid, func, addr, length, entry_index,
               entry_base, entry_mask, entry_type, entry_valid,
        input  ready
    );

    modport sink (
        input  valid, func, addr, length, entry_index,
               entry_base, entry_mask, entry_type, entry_valid,
        output ready
    );

endinterface
`default_nettype wire

// ===== design/mtrr_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtrr_rsp_if
// Response channel: memory type, status and allocated entry.
// ----------------------------------------------------------------------------
interface mtrr_rsp_if;
    import mtrr_pkg::*;

    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   mem_type;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   entry_used;

    modport source (
        output valid, mem_type, status, entry_used,
        input  ready
    );

    modport sink (
        input  valid, mem_type, status, entry_used,
        output ready
    );

endinterface
`default_nettype wire

// ===== design/memory_type_range_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// memory_type_range_table_top
// Variable memory-type range table with lookup, entry write and
// write-combining install; one response beat per request beat.
// ----------------------------------------------------------------------------
// One request is worked at a time; a new request is taken while the previous
// response still waits in the output register. Every request passes the
// accept (idle), decode and finish states; the finish state repeats while
// the previous response still waits unaccepted. Let n be ranges_in_use capped
// at MAX_RANGES. A lookup examines one table entry at a time from entry 0
// until a hit or the end of the n active entries. A write goes from decode
// to finish, and so does an install that fails its range or support check.
// An install walks the table once per 4 KiB page of the range; at the first
// page that is not write-combining it stops and searches the n active entries
// for a free one. All table reads go through the single walk pointer.
// ----------------------------------------------------------------------------
module memory_type_range_table_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mtrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mtrr_pkg::CFG_DATA_W-1:0] cfg_data,
    mtrr_req_if.sink                            req,
    mtrr_rsp_if.source                          rsp
);
    import mtrr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mtrr_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mtrr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

// ===== design/mtrr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtrr_datapath
// Range table, configuration registers, operand capture, entry walk pointer,
// page walker and result/output registers.
// ----------------------------------------------------------------------------
module mtrr_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mtrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mtrr_pkg::CFG_DATA_W-1:0] cfg_data,
    mtrr_req_if.sink                            req,
    mtrr_rsp_if.source                          rsp,
    input  wire mtrr_pkg::cmd_t                 cmd,
    output mtrr_pkg::stat_t                     stat
);
    import mtrr_pkg::*;

    logic [TYPE_W-1:0]     default_type_reg;
    logic [RIU_W-1:0]      ranges_in_use_reg;
    logic                  wc_supported_reg;

    logic [PFN_W-1:0]      base_reg  [MAX_RANGES];
    logic [PFN_W-1:0]      mask_reg  [MAX_RANGES];
    logic [TYPE_W-1:0]     type_reg  [MAX_RANGES];
    logic [MAX_RANGES-1:0] valid_reg;

    func_t                 func_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [EIDX_W-1:0]     eidx_reg;
    logic [PFN_W-1:0]      ebase_reg;
    logic [PFN_W-1:0]      emask_reg;
    logic [TYPE_W-1:0]     etype_reg;
    logic                  evalid_reg;

    logic [ADDR_W-1:0]     page_addr_reg;
    logic [PAGE_CNT_W-1:0] left_reg;
    logic [CNT_W-1:0]      idx_reg;

    logic [TYPE_W-1:0]     res_type_reg;
    status_t               res_status_reg;
    logic [USED_W-1:0]     res_used_reg;
    logic                  out_valid_reg;

    logic [CNT_W-1:0]      active_cnt;
    logic [IDX_W-1:0]      cur;
    logic [IDX_W-1:0]      widx;
    logic [PFN_W-1:0]      pfn;
    logic                  idx_end;
    logic                  hit;
    logic [TYPE_W-1:0]     resolved_type;
    logic                  accept;

    assign accept = req.valid && cmd.take;

    always_comb
    begin
        if (32'(ranges_in_use_reg) > MAX_RANGES)
        begin
            active_cnt = CNT_W'(MAX_RANGES);
        end
        else
        begin
            active_cnt = CNT_W'(ranges_in_use_reg);
        end
    end

    assign cur           = idx_reg[IDX_W-1:0];
    assign widx          = IDX_W'(eidx_reg);
    assign pfn           = page_addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign idx_end       = (idx_reg >= active_cnt);
    assign hit           = valid_reg[cur] &&
                           ((pfn & mask_reg[cur]) == (base_reg[cur] & mask_reg[cur]));
    assign resolved_type = idx_end ? default_type_reg : type_reg[cur];

    always_comb
    begin
        stat.req_valid    = req.valid;
        stat.func         = func_reg;
        stat.bad_range    = (len_reg == '0) ||
                            ((addr_reg[PAGE_SHIFT-1:0] | len_reg[PAGE_SHIFT-1:0]) != '0);
        stat.wc_supported = wc_supported_reg;
        stat.idx_end      = idx_end;
        stat.hit          = hit;
        stat.entry_valid  = valid_reg[cur];
        stat.type_is_wc   = (resolved_type == TYPE_WC);
        stat.last_page    = (left_reg == PAGE_CNT_W'(1));
        stat.out_busy     = out_valid_reg && !rsp.ready;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_type_reg  <= '0;
            ranges_in_use_reg <= RIU_W'(8);
            wc_supported_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEFAULT_TYPE:  default_type_reg  <= cfg_data[TYPE_W-1:0];
                CFG_RANGES_IN_USE: ranges_in_use_reg <= cfg_data[RIU_W-1:0];
                CFG_WC_SUPPORTED:  wc_supported_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // table valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write_entry && (32'(eidx_reg) < MAX_RANGES))
        begin
            valid_reg[widx] <= evalid_reg;
        end
        else if (cmd.program_entry)
        begin
            valid_reg[cur] <= 1'b1;
        end
    end

    // table payload
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && (32'(eidx_reg) < MAX_RANGES))
        begin
            base_reg[widx] <= ebase_reg;
            mask_reg[widx] <= emask_reg;
            type_reg[widx] <= etype_reg;
        end
        else if (cmd.program_entry)
        begin
            base_reg[cur] <= addr_reg[ADDR_W-1:PAGE_SHIFT];
            mask_reg[cur] <= mask_for_length(len_reg);
            type_reg[cur] <= TYPE_WC;
        end
    end

    // operand capture and page walker
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= func_t'(req.func);
            addr_reg      <= req.addr;
            len_reg       <= req.length;
            eidx_reg      <= req.entry_index;
            ebase_reg     <= req.entry_base;
            emask_reg     <= req.entry_mask;
            etype_reg     <= req.entry_type;
            evalid_reg    <= req.entry_valid;
            page_addr_reg <= req.addr;
            left_reg      <= req.length[LEN_W-1:PAGE_SHIFT];
        end
        else if (cmd.page_next)
        begin
            page_addr_reg <= page_addr_reg + ADDR_W'(1 << PAGE_SHIFT);
            left_reg      <= left_reg - PAGE_CNT_W'(1);
        end
    end

    // entry walk pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // result registers; a load in the decode cycle wins over the clear
    always_ff @(posedge clk)
    begin
        if (cmd.type_load)
        begin
            res_type_reg <= resolved_type;
        end
        else if (cmd.res_clear)
        begin
            res_type_reg <= '0;
        end

        if (cmd.status_load)
        begin
            res_status_reg <= cmd.status;
        end
        else if (cmd.res_clear)
        begin
            res_status_reg <= ST_DONE;
        end

        if (cmd.used_load)
        begin
            res_used_reg <= USED_W'(idx_reg);
        end
        else if (cmd.res_clear)
        begin
            res_used_reg <= '0;
        end
    end

    // output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp.mem_type   <= res_type_reg;
            rsp.status     <= res_status_reg;
            rsp.entry_used <= res_used_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign req.ready = cmd.take;

endmodule
`default_nettype wire

// ===== design/mtrr_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtrr_controller
// Sequencer for lookup, entry write and write-combining install.
// ----------------------------------------------------------------------------
module mtrr_controller (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mtrr_pkg::stat_t stat,
    output mtrr_pkg::cmd_t       cmd
);
    import mtrr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   resolved;

    assign resolved = stat.idx_end || stat.hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.func)
                    FUNC_LOOKUP:  state_next = S_LOOK;
                    FUNC_INSTALL: state_next = (stat.bad_range || !stat.wc_supported) ?
                                               S_FINISH : S_PAGE;
                    default:      state_next = S_FINISH;
                endcase
            end
            S_LOOK:
            begin
                if (resolved)
                begin
                    state_next = S_FINISH;
                end
            end
            S_PAGE:
            begin
                if (resolved)
                begin
                    if (!stat.type_is_wc)
                    begin
                        state_next = S_FREE;
                    end
                    else if (stat.last_page)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FREE:
            begin
                if (stat.idx_end || !stat.entry_valid)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.status = ST_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
            end
            S_DECODE:
            begin
                cmd.res_clear = 1'b1;
                cmd.idx_clr   = 1'b1;
                if (stat.func == FUNC_WRITE)
                begin
                    cmd.write_entry = 1'b1;
                end
            end
            S_LOOK:
            begin
                if (resolved)
                begin
                    cmd.type_load = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_PAGE:
            begin
                if (resolved)
                begin
                    if (!stat.type_is_wc)
                    begin
                        cmd.idx_clr = 1'b1;
                    end
                    else if (stat.last_page)
                    begin
                        cmd.status_load = 1'b1;
                        cmd.status      = ST_COVERED;
                    end
                    else
                    begin
                        cmd.page_next = 1'b1;
                        cmd.idx_clr   = 1'b1;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FREE:
            begin
                if (stat.idx_end)
                begin
                    cmd.status_load = 1'b1;
                    cmd.status      = ST_NO_FREE;
                end
                else if (!stat.entry_valid)
                begin
                    cmd.program_entry = 1'b1;
                    cmd.used_load     = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default: ;
        endcase

        // range checks resolve in the decode cycle
        if (state_reg == S_DECODE && stat.func == FUNC_INSTALL)
        begin
            if (stat.bad_range)
            begin
                cmd.status_load = 1'b1;
                cmd.status      = ST_UNALIGNED;
            end
            else if (!stat.wc_supported)
            begin
                cmd.status_load = 1'b1;
                cmd.status      = ST_UNSUPPORTED;
            end
        end
    end

endmodule
`default_nettype wire
